// ===== rtl/core/mvsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mvsm_pkg;

    localparam int DEF_VOICES = 8;
    localparam int DEF_SAMPLE_ADDR_BITS = 16;

    localparam logic [1:0] KIND_FRAME  = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_VOLUME = 2'd2;
    localparam logic [1:0] KIND_START  = 2'd3;

    localparam logic signed [15:0] CLIP_HIGH = 16'sh7fff;
    localparam logic signed [15:0] CLIP_LOW  = -16'sh8000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // register the accepted item
        logic do_sample;   // write the sample byte
        logic do_volume;   // write the volume entries
        logic do_start;    // start a voice
        logic clear_acc;   // clear accumulators for a new frame
        logic voice_check; // test the current voice and read its byte
        logic vol_read;    // read the volume tables with the byte
        logic vol_add;     // add the volume data and advance the voice
        logic next_voice;  // move to the next voice
        logic load_out;    // put the frame into the output register
    } mvsm_cmd_t;

    typedef struct packed {
        logic last_voice;
        logic out_busy;
        logic [1:0] kind;
    } mvsm_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/mvsm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mvsm_datapath
    import mvsm_pkg::*;
#(
    parameter int VOICES = DEF_VOICES,
    parameter int SAMPLE_ADDR_BITS = DEF_SAMPLE_ADDR_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mvsm_cmd_t           cmd,
    output mvsm_status_t             status,
    input  wire logic [1:0]          kind,
    input  wire logic [2:0]          voice,
    input  wire logic [15:0]         address,
    input  wire logic signed [16:0]  value,
    input  wire logic                side,
    input  wire logic [23:0]         step,
    input  wire logic [15:0]         length,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic signed [15:0]       left_sample,
    output logic signed [15:0]       right_sample,
    output logic [7:0]               voices_ended
);

    localparam int VB = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int TB = VB + 8;
    localparam int SDEPTH = 1 << SAMPLE_ADDR_BITS;
    localparam int TDEPTH = VOICES * 256;

    // Captured item.
    logic [1:0] kind_reg;
    logic [2:0] voice_reg;
    logic [15:0] address_reg;
    logic signed [16:0] value_reg;
    logic side_reg;
    logic [23:0] step_reg;
    logic [15:0] length_reg;

    logic [7:0] sample_mem [SDEPTH];
    logic signed [16:0] left_mem [TDEPTH];
    logic signed [16:0] right_mem [TDEPTH];

    logic [VOICES-1:0] active_reg;
    logic [15:0] base_reg [VOICES];
    logic [15:0] pos_reg [VOICES];
    logic [15:0] frac_reg [VOICES];
    logic [23:0] vstep_reg [VOICES];
    logic [15:0] vlen_reg [VOICES];

    logic [VB-1:0] cur_reg;
    logic play_reg;
    logic [7:0] byte_reg;
    logic signed [16:0] lvol_reg, rvol_reg;
    logic signed [20:0] lacc_reg, racc_reg;
    logic [7:0] ended_reg;
    logic out_valid_reg;
    logic signed [15:0] left_reg, right_reg;

    logic voice_ok;
    logic signed [17:0] remain;
    logic fits;
    logic [SAMPLE_ADDR_BITS-1:0] rd_addr;
    logic [16:0] acc;
    logic [TB-1:0] wr_idx;
    logic [TB-1:0] rd_idx;

    function automatic logic signed [15:0] clip(input logic signed [20:0] s);
        if (s > 21'(CLIP_HIGH)) begin
            clip = CLIP_HIGH;
        end
        else if (s < 21'(CLIP_LOW)) begin
            clip = CLIP_LOW;
        end
        else begin
            clip = s[15:0];
        end
    endfunction

    assign voice_ok = ({29'd0, voice_reg} < 32'(VOICES));
    // Remaining bytes scaled by 65536, compared with the 24-bit step.
    assign remain = {2'b00, vlen_reg[cur_reg]} - {2'b00, pos_reg[cur_reg]};
    assign fits = !remain[17] && ({remain[15:0], 16'd0} >= {8'd0, vstep_reg[cur_reg]});
    assign rd_addr = SAMPLE_ADDR_BITS'(32'(base_reg[cur_reg]) + 32'(pos_reg[cur_reg]));
    assign acc = {1'b0, frac_reg[cur_reg]} + {1'b0, vstep_reg[cur_reg][15:0]};
    assign wr_idx = {VB'(voice_reg), address_reg[7:0]};
    assign rd_idx = {cur_reg, byte_reg};

    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            kind_reg <= kind;
            voice_reg <= voice;
            address_reg <= address;
            value_reg <= value;
            side_reg <= side;
            step_reg <= step;
            length_reg <= length;
        end
        if (cmd.do_sample) begin
            sample_mem[SAMPLE_ADDR_BITS'(address_reg)] <= value_reg[7:0];
        end
        if (cmd.do_volume && voice_ok && !side_reg) begin
            left_mem[wr_idx] <= value_reg;
        end
        if (cmd.do_volume && voice_ok && side_reg) begin
            right_mem[wr_idx] <= value_reg;
        end
        if (cmd.voice_check) begin
            byte_reg <= sample_mem[rd_addr];
        end
        if (cmd.vol_read) begin
            lvol_reg <= left_mem[rd_idx];
            rvol_reg <= right_mem[rd_idx];
        end
        if (cmd.load_out) begin
            left_reg <= clip(lacc_reg);
            right_reg <= clip(racc_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            active_reg <= '0;
            for (int i = 0; i < VOICES; i++) begin
                base_reg[i] <= '0;
                pos_reg[i] <= '0;
                frac_reg[i] <= '0;
                vstep_reg[i] <= '0;
                vlen_reg[i] <= '0;
            end
            cur_reg <= '0;
            play_reg <= 1'b0;
            lacc_reg <= '0;
            racc_reg <= '0;
            ended_reg <= '0;
            out_valid_reg <= 1'b0;
            voices_ended <= '0;
        end
        else begin
            if (cmd.do_start && voice_ok) begin
                active_reg[VB'(voice_reg)] <= 1'b1;
                base_reg[VB'(voice_reg)] <= address_reg;
                pos_reg[VB'(voice_reg)] <= '0;
                frac_reg[VB'(voice_reg)] <= '0;
                vstep_reg[VB'(voice_reg)] <= step_reg;
                vlen_reg[VB'(voice_reg)] <= length_reg;
            end
            if (cmd.clear_acc) begin
                lacc_reg <= '0;
                racc_reg <= '0;
                ended_reg <= '0;
                cur_reg <= '0;
            end
            if (cmd.voice_check) begin
                play_reg <= active_reg[cur_reg] && fits;
                if (active_reg[cur_reg] && !fits) begin
                    active_reg[cur_reg] <= 1'b0;
                    ended_reg[3'(cur_reg)] <= 1'b1;
                end
            end
            if (cmd.vol_add && play_reg) begin
                lacc_reg <= lacc_reg + 21'(lvol_reg);
                racc_reg <= racc_reg + 21'(rvol_reg);
                pos_reg[cur_reg] <= pos_reg[cur_reg] + {8'd0, vstep_reg[cur_reg][23:16]}
                                    + {15'd0, acc[16]};
                frac_reg[cur_reg] <= acc[15:0];
            end
            if (cmd.next_voice) begin
                cur_reg <= cur_reg + VB'(1);
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
                voices_ended <= ended_reg;
            end
            else if (out_valid_reg && !out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.last_voice = (32'(cur_reg) == VOICES - 1);
    assign status.out_busy = out_valid_reg && out_stall;
    assign status.kind = kind_reg;
    assign out_valid = out_valid_reg;
    assign left_sample = left_reg;
    assign right_sample = right_reg;

endmodule
`default_nettype wire

// ===== rtl/core/mvsm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mvsm_ctrl
    import mvsm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire mvsm_status_t status,
    output mvsm_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_CHECK, S_VREAD, S_ADD, S_OUT
    } state_t;

    state_t state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (status.kind)
                    KIND_SAMPLE: begin
                        cmd.do_sample = 1'b1;
                        state_next = S_IDLE;
                    end
                    KIND_VOLUME: begin
                        cmd.do_volume = 1'b1;
                        state_next = S_IDLE;
                    end
                    KIND_START: begin
                        cmd.do_start = 1'b1;
                        state_next = S_IDLE;
                    end
                    default: begin
                        cmd.clear_acc = 1'b1;
                        state_next = S_CHECK;
                    end
                endcase
            end
            S_CHECK: begin
                cmd.voice_check = 1'b1;
                state_next = S_VREAD;
            end
            S_VREAD: begin
                cmd.vol_read = 1'b1;
                state_next = S_ADD;
            end
            S_ADD: begin
                cmd.vol_add = 1'b1;
                if (status.last_voice) begin
                    state_next = S_OUT;
                end
                else begin
                    cmd.next_voice = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_OUT: begin
                if (!status.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/multi_voice_sample_mixer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Eight-voice sample mixer. Input items arrive on in_valid/in_stall with one
// port per field. A sample load, volume load or voice start passes through
// a decode state and makes no output item. A frame request walks the voices
// in turn, each through a state test and sample read, a volume table read,
// and an accumulate and advance. The frame then goes out on out_valid/out_stall
// as one item with clipped left and right sums and the mask of voices that
// ended.
// The output register holds a finished frame while the receiver stalls; the
// block accepts the next item meanwhile, and only a later frame waits for the
// register to drain. Reset clears all voices to inactive and empties the
// output register. Sample and volume memories are undefined until written.
module multi_voice_sample_mixer_core
    import mvsm_pkg::*;
#(
    parameter int VOICES = DEF_VOICES,
    parameter int SAMPLE_ADDR_BITS = DEF_SAMPLE_ADDR_BITS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         kind,
    input  wire logic [2:0]         voice,
    input  wire logic [15:0]        address,
    input  wire logic signed [16:0] value,
    input  wire logic               side,
    input  wire logic [23:0]        step,
    input  wire logic [15:0]        length,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      left_sample,
    output logic signed [15:0]      right_sample,
    output logic [7:0]              voices_ended
);

    mvsm_cmd_t cmd;
    mvsm_status_t status;

    // Sequencer: decodes each item and steps the frame walk.
    mvsm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .status(status), .cmd(cmd)
    );

    // Memories, voice state, accumulators and the output register.
    mvsm_datapath #(.VOICES(VOICES), .SAMPLE_ADDR_BITS(SAMPLE_ADDR_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .kind(kind), .voice(voice), .address(address), .value(value),
        .side(side), .step(step), .length(length),
        .out_valid(out_valid), .out_stall(out_stall),
        .left_sample(left_sample), .right_sample(right_sample),
        .voices_ended(voices_ended)
    );

endmodule
`default_nettype wire
